// ===== rtl/core/lzwd_pkg.sv =====
// Shared types and constants for the LZW stream decoder.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

  // Item operation: feed a compressed byte or pull a decoded byte
  typedef enum logic {
    OP_FEED = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_CORRUPT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Configuration register indexes
  localparam logic CFG_MAX_BITS   = 1'b0;
  localparam logic CFG_BLOCK_MODE = 1'b1;

  localparam int unsigned CFG_DATA_W     = 5;
  localparam int unsigned MIN_CODE_BITS  = 9;
  localparam int unsigned LITERAL_CODES  = 256;
  localparam int unsigned CLEAR_CODE     = 256;
  localparam int unsigned FIRST_LIMIT    = 511;
  localparam int unsigned BIT_BUF_W      = 24;

  typedef struct packed {
    op_e        mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic [1:0] status;
  } out_item_t;

  // Head of the item queue as seen by the engine
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PULL,
    BK_WALK,
    BK_FINISH,
    BK_WIDEN,
    BK_EMIT
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/lzwd_if.sv =====
// Valid/ready channel interfaces for items and results of the decoder.
// Depends on lzwd_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface lzwd_in_if;
  logic               valid;
  logic               ready;
  lzwd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lzwd_out_if;
  logic                valid;
  logic                ready;
  lzwd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lzwd_front.sv =====
// Front end: accepts items and holds them in a two-entry queue.
// Depends on lzwd_pkg and lzwd_if.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_front (
  input  wire                  clk,
  input  wire                  rst,
  lzwd_in_if.sink              din,
  input  wire                  pop,
  output lzwd_pkg::queue_head_t head
);
  import lzwd_pkg::*;

  in_item_t   ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  assign din.ready = (count != 2'd2);
  assign push      = din.valid && din.ready;
  assign take      = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = ent[rd_ptr];

  // Store accepted items
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din.data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(take);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lzwd_back.sv =====
// Back end: code extraction, table walk, expand stack and result register.
// Depends on lzwd_pkg and lzwd_if.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_back #(
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire                   cfg_index,
  input  wire  [4:0]            cfg_data,
  input  lzwd_pkg::queue_head_t head,
  output logic                  pop,
  lzwd_out_if.source            dout
);
  import lzwd_pkg::*;

  localparam int unsigned AW    = MAX_CODE_BITS;
  localparam int unsigned LW    = AW + 1;
  localparam int unsigned DEPTH = 1 << AW;

  // Tables and stack
  logic [AW-1:0] pre_mem [DEPTH];
  logic [7:0]    suf_mem [DEPTH];
  logic [7:0]    stk_mem [DEPTH];

  back_state_e state, state_next;
  logic [1:0]    err, err_next;
  logic [LW-1:0] level, level_next;
  logic [BIT_BUF_W-1:0] bbuf, bbuf_next;
  logic [4:0]    held, held_next;
  logic [4:0]    cw, cw_next;
  logic [LW-1:0] limit, limit_next;
  logic [LW-1:0] nf, nf_next;
  logic [AW-1:0] prev, prev_next;
  logic          have, have_next;
  logic [7:0]    first, first_next;
  logic [4:0]    gbc, gbc_next;
  logic [4:0]    skip, skip_next;
  logic [AW-1:0] incode, incode_next;
  logic [AW-1:0] cptr, cptr_next;
  out_item_t     res, res_next;
  logic [4:0]    max_bits;
  logic          bmode;
  logic          ov;
  out_item_t     od;
  logic          out_load;

  logic          tbl_re, tbl_we, stk_re, stk_we;
  logic [AW-1:0] tbl_raddr, stk_raddr;
  logic [7:0]    stk_wdata;
  logic [AW-1:0] pre_q;
  logic [7:0]    suf_q, stk_q;

  logic [4:0]    eb;
  logic [LW-1:0] maxmax;
  logic [BIT_BUF_W-1:0] bnew;
  logic [4:0]    hnew, gnew, cwn;
  logic [AW-1:0] code, cwalk;
  logic          bm_new;

  // Saturate the configured width into the supported range
  always_comb begin
    if (max_bits < 5'(MIN_CODE_BITS))  eb = 5'(MIN_CODE_BITS);
    else if (max_bits > 5'(AW))        eb = 5'(AW);
    else                               eb = max_bits;
  end
  assign maxmax = LW'(1) << eb;
  assign bm_new = (cfg_index == CFG_BLOCK_MODE) ? cfg_data[0] : bmode;

  // Table memories
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      pre_mem[nf[AW-1:0]] <= prev;
      suf_mem[nf[AW-1:0]] <= cptr[7:0];
    end
    if (tbl_re) begin
      pre_q <= pre_mem[tbl_raddr];
      suf_q <= suf_mem[tbl_raddr];
    end
  end

  // Expand stack memory
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[level[AW-1:0]] <= stk_wdata;
    if (stk_re) stk_q <= stk_mem[stk_raddr];
  end

  // Next state and datapath
  always_comb begin
    state_next  = state;
    err_next    = err;
    level_next  = level;
    bbuf_next   = bbuf;
    held_next   = held;
    cw_next     = cw;
    limit_next  = limit;
    nf_next     = nf;
    prev_next   = prev;
    have_next   = have;
    first_next  = first;
    gbc_next    = gbc;
    skip_next   = skip;
    incode_next = incode;
    cptr_next   = cptr;
    res_next    = res;
    pop         = 1'b0;
    out_load    = 1'b0;
    tbl_re      = 1'b0;
    tbl_we      = 1'b0;
    tbl_raddr   = pre_q;
    stk_re      = 1'b0;
    stk_we      = 1'b0;
    stk_raddr   = AW'(level - LW'(1));
    stk_wdata   = suf_q;
    bnew        = bbuf | (BIT_BUF_W'(head.item.data_byte) << held);
    hnew        = held + 5'd8;
    gnew        = (gbc + 5'd1 >= cw) ? 5'd0 : gbc + 5'd1;
    code        = AW'(bnew & ((BIT_BUF_W'(1) << cw) - BIT_BUF_W'(1)));
    cwalk       = code;
    cwn         = cw + 5'd1;

    unique case (state)
      BK_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          res_next = '{out_byte: 8'd0, out_valid: 1'b0, out_last: 1'b0, status: err};
          if (head.item.mode == OP_PULL) begin
            if (level != '0) begin
              stk_re     = 1'b1;
              level_next = level - LW'(1);
              state_next = BK_PULL;
            end else begin
              state_next = BK_EMIT;
            end
          end else begin
            state_next = BK_EMIT;
            priority if (err != ST_OK) begin
              res_next.status = err;
            end else if (level != '0) begin
              res_next.status = ST_REFUSED;
            end else if (skip != '0) begin
              skip_next = skip - 5'd1;
            end else begin
              gbc_next = gnew;
              if (hnew < cw) begin
                bbuf_next = bnew;
                held_next = hnew;
              end else begin
                bbuf_next = bnew >> cw;
                held_next = hnew - cw;
                priority if (!have) begin
                  if (code >= AW'(LITERAL_CODES)) begin
                    err_next        = ST_CORRUPT;
                    res_next.status = ST_CORRUPT;
                  end else begin
                    stk_we     = 1'b1;
                    stk_wdata  = code[7:0];
                    level_next = level + LW'(1);
                    prev_next  = code;
                    first_next = code[7:0];
                    have_next  = 1'b1;
                    state_next = BK_WIDEN;
                  end
                end else if (code == AW'(CLEAR_CODE) && bmode) begin
                  // Table clear: drop the rest of the group and restart widths
                  nf_next = LW'(CLEAR_CODE + 1);
                  if (gnew != '0) skip_next = cw - gnew;
                  gbc_next   = '0;
                  bbuf_next  = '0;
                  held_next  = '0;
                  have_next  = 1'b0;
                  cw_next    = 5'(MIN_CODE_BITS);
                  limit_next = LW'(FIRST_LIMIT);
                end else if (LW'(code) > nf) begin
                  err_next        = ST_CORRUPT;
                  res_next.status = ST_CORRUPT;
                end else begin
                  incode_next = code;
                  if (LW'(code) == nf) begin
                    // Code not yet in the table: string of previous plus its first byte
                    stk_we     = 1'b1;
                    stk_wdata  = first;
                    level_next = level + LW'(1);
                    cwalk      = prev;
                  end
                  if (cwalk >= AW'(LITERAL_CODES)) begin
                    tbl_re     = 1'b1;
                    tbl_raddr  = cwalk;
                    state_next = BK_WALK;
                  end else begin
                    cptr_next  = cwalk;
                    state_next = BK_FINISH;
                  end
                end
              end
            end
          end
        end
      end
      BK_PULL: begin
        res_next   = '{out_byte: stk_q, out_valid: 1'b1,
                       out_last: (level == '0), status: err};
        state_next = BK_EMIT;
      end
      BK_WALK: begin
        // Push one suffix per cycle and follow the prefix link
        if (level == LW'(DEPTH)) begin
          err_next        = ST_OVERFLOW;
          level_next      = '0;
          res_next.status = ST_OVERFLOW;
          state_next      = BK_EMIT;
        end else begin
          stk_we     = 1'b1;
          stk_wdata  = suf_q;
          level_next = level + LW'(1);
          if (pre_q >= AW'(LITERAL_CODES)) begin
            tbl_re    = 1'b1;
            tbl_raddr = pre_q;
          end else begin
            cptr_next  = pre_q;
            state_next = BK_FINISH;
          end
        end
      end
      BK_FINISH: begin
        // Push the root byte and add the new table entry while the table has room
        first_next = cptr[7:0];
        if (level == LW'(DEPTH)) begin
          err_next        = ST_OVERFLOW;
          level_next      = '0;
          res_next.status = ST_OVERFLOW;
          state_next      = BK_EMIT;
        end else begin
          stk_we     = 1'b1;
          stk_wdata  = cptr[7:0];
          level_next = level + LW'(1);
          if (nf < maxmax) begin
            tbl_we  = 1'b1;
            nf_next = nf + LW'(1);
          end
          prev_next  = incode;
          state_next = BK_WIDEN;
        end
      end
      BK_WIDEN: begin
        // Grow the code width once the free code passes the limit
        state_next = BK_EMIT;
        if (nf > limit) begin
          if (gbc != '0) skip_next = cw - gbc;
          gbc_next  = '0;
          bbuf_next = '0;
          held_next = '0;
          cw_next   = cwn;
          if (cwn >= eb) begin
            if (cwn > eb && (eb > 5'(MIN_CODE_BITS) || limit > LW'(FIRST_LIMIT))) begin
              err_next        = ST_CORRUPT;
              level_next      = '0;
              res_next.status = ST_CORRUPT;
            end else begin
              limit_next = maxmax;
            end
          end else begin
            limit_next = (LW'(1) << cwn) - LW'(1);
          end
        end
      end
      BK_EMIT: begin
        if (!ov || dout.ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // State register, restarted by reset or any configuration write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state  <= BK_IDLE;
      err    <= ST_OK;
      level  <= '0;
      bbuf   <= '0;
      held   <= '0;
      cw     <= 5'(MIN_CODE_BITS);
      limit  <= LW'(FIRST_LIMIT);
      prev   <= '0;
      have   <= 1'b0;
      first  <= '0;
      gbc    <= '0;
      skip   <= '0;
      if (rst) begin
        max_bits <= 5'd16;
        bmode    <= 1'b1;
        nf       <= LW'(CLEAR_CODE + 1);
      end else begin
        if (cfg_index == CFG_MAX_BITS) max_bits <= cfg_data;
        bmode <= bm_new;
        nf    <= bm_new ? LW'(CLEAR_CODE + 1) : LW'(CLEAR_CODE);
      end
    end else begin
      state <= state_next;
      err   <= err_next;
      level <= level_next;
      bbuf  <= bbuf_next;
      held  <= held_next;
      cw    <= cw_next;
      limit <= limit_next;
      nf    <= nf_next;
      prev  <= prev_next;
      have  <= have_next;
      first <= first_next;
      gbc   <= gbc_next;
      skip  <= skip_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    incode <= incode_next;
    cptr   <= cptr_next;
    res    <= res_next;
    if (out_load) od <= res;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_load) begin
      ov <= 1'b1;
    end else if (dout.ready) begin
      ov <= 1'b0;
    end
  end

  assign dout.valid = ov;
  assign dout.data  = od;

endmodule

`default_nettype wire

// ===== rtl/core/lzw_stream_decoder_top.sv =====
// Top level of the LZW stream decoder: item queue feeding the decode engine.
// Depends on lzwd_pkg, lzwd_if, lzwd_front and lzwd_back.
//
//  channel | dir | payload                                  | handshake
//  din     | in  | mode, data_byte                          | valid/ready
//  dout    | out | out_byte, out_valid, out_last, status    | valid/ready
//  cfg     | in  | cfg_index, cfg_data (write only)         | cfg_we
//
// One item is worked at a time by the engine; the queue keeps taking items.
// Path from the queue: a feed that completes no code, a refused, skipped or
// rejected feed, a clear or an empty pull go straight to the emit step; a pull
// reads the stack first; the first literal code passes the widen step; others
// walk their table chain, if any (one table read per cycle), then finish and widen.
// Reset and every configuration write restart the stream; tables keep data.
// A stalled result holds the engine in its emit step; the queue then fills.
`timescale 1ns / 1ps
`default_nettype none

module lzw_stream_decoder_top #(
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire  [4:0] cfg_data,
  lzwd_in_if.sink    din,
  lzwd_out_if.source dout
);
  import lzwd_pkg::*;

  queue_head_t head;
  logic        pop;

  lzwd_front u_front (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .pop  (pop),
    .head (head)
  );

  lzwd_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .dout      (dout)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lzwd_checker.sv =====
// Port-level checks of the decoder's result channel, bound to the top level.
// Depends on lzw_stream_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_checker (
  input wire       clk,
  input wire       rst,
  input wire       dout_valid,
  input wire       dout_ready,
  input wire [7:0] out_byte,
  input wire       out_valid,
  input wire       out_last,
  input wire [1:0] status
);
  import lzwd_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !dout_valid)
    else $error("result presented right after reset");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (dout_valid && !out_valid) |-> (out_byte == 8'd0 && !out_last))
    else $error("result without a byte carries data");

  a_refused_no_byte: assert property (@(posedge clk) disable iff (rst)
    (dout_valid && status == ST_REFUSED) |-> !out_valid)
    else $error("refused feed reports a byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (dout_valid && !dout_ready) |=> (dout_valid && $stable(out_byte) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind lzw_stream_decoder_top lzwd_checker u_lzwd_checker (
  .clk        (clk),
  .rst        (rst),
  .dout_valid (dout.valid),
  .dout_ready (dout.ready),
  .out_byte   (dout.data.out_byte),
  .out_valid  (dout.data.out_valid),
  .out_last   (dout.data.out_last),
  .status     (dout.data.status)
);

`default_nettype wire

// ===== tb/sv/lzw_stream_decoder_top_test.sv =====
// Self-checking bench for lzw_stream_decoder_top: builds compress streams, some corrupt,
// drives them with random idling and checks every result against a local decoder.
// Depends on lzwd_pkg, lzwd_if and the decoder RTL.
`timescale 1ns / 1ps

module lzw_stream_decoder_top_test;
  import lzwd_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_MAX_BITS;
  logic [4:0] cfg_data = '0;

  lzwd_in_if  din ();
  lzwd_out_if dout ();

  lzw_stream_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din),
    .dout      (dout)
  );

  always #4 clk = ~clk;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        n_mismatch = 0;
  int        n_in = 0;
  int        n_out = 0;
  int        n_streams = 0;
  bit        in_taken = 1'b0;

  // ---------------------------------------------------------------- decoder copy
  logic [4:0]  reg_max_bits;
  logic        reg_block;
  logic [15:0] prefix_mem [0:65536];
  logic [7:0]  suffix_mem [0:65536];
  logic [7:0]  stack_mem  [0:65535];
  int unsigned d_level, d_buf, d_held, d_width, d_limit, d_next, d_prev;
  int unsigned d_first, d_group, d_skip;
  bit          d_have;
  logic [1:0]  d_err;

  function automatic int unsigned eff_width(logic [4:0] m);
    if (m < 9) return 9;
    if (m > 16) return 16;
    return m;
  endfunction

  function automatic void dec_restart();
    d_level = 0; d_buf = 0; d_held = 0; d_width = 9; d_limit = 511;
    d_next = reg_block ? 257 : 256;
    d_prev = 0; d_have = 0; d_first = 0; d_group = 0; d_skip = 0; d_err = ST_OK;
  endfunction

  function automatic void dec_align();
    if (d_group != 0) d_skip = d_width - d_group;
    d_group = 0; d_buf = 0; d_held = 0;
  endfunction

  function automatic bit dec_push(int unsigned v);
    if (d_level >= 65536) begin
      d_err = ST_OVERFLOW;
      d_level = 0;
      return 0;
    end
    stack_mem[d_level] = v[7:0];
    d_level++;
    return 1;
  endfunction

  function automatic void dec_code(int unsigned code);
    int unsigned top, incode, c;
    top = 1 << eff_width(reg_max_bits);
    if (!d_have) begin
      if (code >= 256) begin
        d_err = ST_CORRUPT;
        return;
      end
      d_prev = code; d_first = code; d_have = 1;
      void'(dec_push(code));
      return;
    end
    // clear command: restart the table at the next group boundary
    if (code == CLEAR_CODE && reg_block) begin
      d_next = 257;
      dec_align();
      d_have = 0; d_width = 9; d_limit = 511;
      return;
    end
    incode = code;
    c = code;
    // KwKwK: code not yet in the table
    if (c >= d_next) begin
      if (c > d_next) begin
        d_err = ST_CORRUPT;
        return;
      end
      if (!dec_push(d_first)) return;
      c = d_prev;
    end
    while (c >= 256) begin
      if (c >= 65537) c = 0;
      if (!dec_push(suffix_mem[c])) return;
      c = prefix_mem[c];
    end
    d_first = suffix_mem[c];
    if (!dec_push(d_first)) return;
    if (d_next < top) begin
      prefix_mem[d_next] = d_prev[15:0];
      suffix_mem[d_next] = d_first[7:0];
      d_next++;
    end
    d_prev = incode;
  endfunction

  function automatic void dec_widen();
    int unsigned eb, top;
    eb = eff_width(reg_max_bits);
    top = 1 << eb;
    if (d_next <= d_limit) return;
    dec_align();
    d_width++;
    if (d_width >= eb) begin
      if (d_width > eb && (top > 512 || d_limit > 511)) begin
        d_err = ST_CORRUPT;
        d_level = 0;
        return;
      end
      d_limit = top;
    end else begin
      d_limit = (1 << d_width) - 1;
    end
  endfunction

  function automatic logic [1:0] dec_feed(logic [7:0] b);
    int unsigned code;
    if (d_err != ST_OK) return d_err;
    if (d_level != 0) return ST_REFUSED;
    if (d_skip != 0) begin
      d_skip--;
      return ST_OK;
    end
    d_buf |= int'(b) << d_held;
    d_held += 8;
    d_group++;
    if (d_group >= d_width) d_group = 0;
    if (d_held < d_width) return ST_OK;
    code = d_buf & ((1 << d_width) - 1);
    d_buf >>= d_width;
    d_held -= d_width;
    dec_code(code);
    if (d_err == ST_OK) dec_widen();
    return d_err;
  endfunction

  function automatic out_item_t dec_step(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.mode == OP_FEED) begin
      r.status = dec_feed(it.data_byte);
    end else begin
      if (d_level != 0) begin
        d_level--;
        r.out_byte = stack_mem[d_level];
        r.out_valid = 1'b1;
        r.out_last = (d_level == 0);
      end
      r.status = d_err;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stream builder
  int          str_len [0:65536];
  int unsigned g_next, g_width, g_limit, g_prev, g_nacc, g_group, g_pend;
  longint      g_acc;
  bit          g_have;
  int          noise_pct;

  function automatic void add_item(op_e op, logic [7:0] b);
    in_item_t it;
    it.mode = op;
    it.data_byte = b;
    pending_items.push_back(it);
  endfunction

  // pulls for the string the last completed code produced, plus some noise
  function automatic void flush_pulls();
    if (g_pend == 0) return;
    if ($urandom_range(99) < noise_pct) add_item(OP_FEED, 8'($urandom_range(255)));
    repeat (g_pend) add_item(OP_PULL, 8'($urandom_range(255)));
    if ($urandom_range(99) < noise_pct) add_item(OP_PULL, 8'($urandom_range(255)));
    g_pend = 0;
  endfunction

  function automatic void gen_restart();
    g_next = reg_block ? 257 : 256;
    g_width = 9; g_limit = 511; g_have = 0;
    g_acc = 0; g_nacc = 0; g_group = 0; g_pend = 0;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    add_item(OP_FEED, b);
    g_group++;
    if (g_group >= g_width) g_group = 0;
    flush_pulls();
  endfunction

  function automatic void put_code(int unsigned c, int unsigned len);
    g_acc |= longint'(c) << g_nacc;
    g_nacc += g_width;
    while (g_nacc >= 8) begin
      emit_byte(g_acc[7:0]);
      g_acc >>= 8;
      g_nacc -= 8;
    end
    g_pend = len;
    if (g_nacc == 0) flush_pulls();
  endfunction

  // close the partial byte and pad the group with filler the decoder skips
  function automatic void gen_align();
    if (g_nacc > 0) emit_byte(g_acc[7:0]);
    g_acc = 0; g_nacc = 0;
    if (g_group != 0) repeat (g_width - g_group) add_item(OP_FEED, 8'($urandom_range(255)));
    g_group = 0;
  endfunction

  function automatic void gen_code(int unsigned c);
    int unsigned top, len;
    top = 1 << eff_width(reg_max_bits);
    if (!g_have) begin
      str_len[c] = 1;
      put_code(c, 1);
      g_have = 1;
      g_prev = c;
      return;
    end
    if (c == CLEAR_CODE && reg_block) begin
      put_code(c, 0);
      g_next = 257;
      gen_align();
      g_have = 0; g_width = 9; g_limit = 511;
      return;
    end
    len = (c == g_next) ? str_len[g_prev] + 1 : str_len[c];
    put_code(c, len);
    if (g_next < top) begin
      str_len[g_next] = str_len[g_prev] + 1;
      g_next++;
    end
    g_prev = c;
    // widen exactly as the decoder does
    if (g_next > g_limit) begin
      gen_align();
      g_width++;
      g_limit = (g_width >= eff_width(reg_max_bits)) ? top : (1 << g_width) - 1;
    end
  endfunction

  function automatic int unsigned pick_code();
    int unsigned top, r;
    top = 1 << eff_width(reg_max_bits);
    r = $urandom_range(99);
    if (!g_have) return $urandom_range(255);
    if (reg_block && r < 3) return CLEAR_CODE;
    if (r < 15 && g_next < top) return g_next;
    if (r < 50 || g_next <= 257) return $urandom_range(255);
    return $urandom_range(g_next - 1, reg_block ? 257 : 256);
  endfunction

  function automatic void end_stream();
    if (g_nacc > 0) emit_byte(g_acc[7:0]);
    g_acc = 0; g_nacc = 0;
  endfunction

  // a code the table cannot hold yet, then traffic under the sticky error
  function automatic void gen_bad(int unsigned c);
    put_code(c, 0);
    end_stream();
    repeat ($urandom_range(4, 1))
      add_item(op_e'($urandom_range(1)), 8'($urandom_range(255)));
  endfunction

  // ---------------------------------------------------------------- sequencing
  task automatic write_reg(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_BITS) reg_max_bits = val;
    else reg_block = val[0];
    dec_restart();
  endtask

  task automatic start_stream(logic [4:0] bits, logic blk);
    write_reg(CFG_MAX_BITS, bits);
    write_reg(CFG_BLOCK_MODE, {4'd0, blk});
    gen_restart();
    n_streams++;
  endtask

  // wait until every item is sent and every result is back, then let the engine settle
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || din.valid || expected_results.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_mismatch++;
  endtask

  // drive one transaction per free slot, idling by phase
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (n_in < 650) ? 12 : (n_in < 1300) ? 61 : 0;
    if (rst) begin
      din.valid <= 1'b0;
    end else if (!(din.valid && !in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        din.valid <= 1'b1;
        din.data <= pending_items.pop_front();
      end else begin
        din.valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // stall the result side by phase
  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (n_in < 650) ? 61 : (n_in < 1300) ? 12 : 0;
    dout.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // predict on every accepted input transaction
  always @(posedge clk) begin
    if (!rst && din.valid && din.ready) begin
      expected_results.push_back(dec_step(din.data));
      in_taken = 1'b1;
      n_in++;
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && dout.valid && dout.ready) begin
      n_out++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, out_byte", dout.data.out_byte, -1);
      end else begin
        want = expected_results.pop_front();
        if (dout.data.out_byte !== want.out_byte)
          report_mismatch("out_byte", dout.data.out_byte, want.out_byte);
        if (dout.data.out_valid !== want.out_valid)
          report_mismatch("out_valid", dout.data.out_valid, want.out_valid);
        if (dout.data.out_last !== want.out_last)
          report_mismatch("out_last", dout.data.out_last, want.out_last);
        if (dout.data.status !== want.status)
          report_mismatch("status", dout.data.status, want.status);
      end
    end
  end

  initial begin
    #30ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    int ncodes, queued;
    din.valid = 1'b0;
    din.data = '0;
    dout.ready = 1'b0;
    reg_max_bits = 5'd16;
    reg_block = 1'b1;
    for (int i = 0; i < 256; i++) begin
      suffix_mem[i] = i[7:0];
      str_len[i] = 1;
    end
    dec_restart();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // literals at both ends, KwKwK, clear, empty pull, refused feeds
    noise_pct = 100;
    start_stream(5'd16, 1'b1);
    add_item(OP_PULL, 8'hff);
    gen_code(0); gen_code(255); gen_code(258); gen_code(257);
    gen_code(CLEAR_CODE); gen_code(65); gen_code(66);
    end_stream();
    drain();
    // no clear command: 256 is an ordinary KwKwK code; then a code past the table
    start_stream(5'd9, 1'b0);
    gen_code(10); gen_code(CLEAR_CODE); gen_code(10);
    gen_bad(300);
    drain();
    // first code not a literal; width register below range
    start_stream(5'd0, 1'b1);
    gen_bad(CLEAR_CODE);
    drain();
    // width register above range, KwKwK on a fresh table
    start_stream(5'd31, 1'b0);
    gen_code(1); gen_code(2); gen_code(257);
    end_stream();
    drain();

    // random streams, the first long enough to fill a 9-bit table
    noise_pct = 15;
    queued = n_in;
    while (queued < 1750) begin
      if (n_streams == 4) start_stream(5'd9, 1'b1);
      else start_stream($urandom_range(3) == 0 ? 5'($urandom_range(31)) :
                        ($urandom_range(1) ? 5'd16 : 5'd9), 1'($urandom_range(1)));
      ncodes = (n_streams == 5) ? 300 : $urandom_range(80, 8);
      repeat (ncodes) gen_code(pick_code());
      if ($urandom_range(99) < 12 && g_have && g_next + 1 < (1 << g_width))
        gen_bad($urandom_range((1 << g_width) - 1, g_next + 1));
      else
        end_stream();
      queued += pending_items.size();
      drain();
    end

    drain();
    $display("%0d input transactions in %0d streams, %0d results checked, %0d mismatches",
             n_in, n_streams, n_out, n_mismatch);
    $display("widths 9..16 with clear, KwKwK, skips, refused feeds and sticky errors exercised");
    if (n_mismatch == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
